[hdl/sus_pkg.sv]
// Shared types and constants for the sort/unique set union unit.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package sus_pkg;

    localparam int VALUE_W       = 32;
    localparam int MAX_ITEMS_DEF = 64;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;        // take one input transfer into the store
        logic emit_empty;  // give the single empty result and clear the load
        logic init_pass;   // open the first scan pass of a run
        logic step;        // read the next stored element
        logic pass_end;    // close a pass: emit pending value or finish
    } sus_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic count_zero;  // no element stored
        logic scan_last;   // read address points at the last stored element
        logic found;       // current pass found a value above the previous one
    } sus_status_t;

endpackage

[hdl/sort_unique_set_union_unit.sv]
// Top level of the sort/unique set union unit.
// Depends on sus_pkg, sus_ctrl and sus_datapath.
//
// Usage:
//   Input: drive value, present and last with start; a transfer happens on a
//   clock edge where start is high and busy is low. Each transfer with present
//   set stores value; once MAX_ITEMS values are held, further ones are dropped
//   and overflow is reported on every result of the run.
//   A transfer with last set starts the run: busy rises and stays high until
//   the final result has been issued.
//   Output: each result shows on value_res/last_res/empty_res/overflow for one
//   cycle with strobe high. Results come in ascending signed order without
//   duplicates; last_res marks the final one. An empty load gives one result
//   with value_res 0, last_res 1 and empty_res 1. The receiver cannot stall.
//   Timing: loading accepts one transfer per cycle. In a run, each distinct
//   value costs one full scan of the store through its single read port, plus
//   one closing scan.
//   Reset (rst_n low, asynchronous) empties the store and clears the overflow
//   flag; busy is low afterwards.
`timescale 1ns / 1ps

module sort_unique_set_union_unit
    import sus_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      present,
    input  logic                      last,
    output logic                      strobe,
    output logic signed [VALUE_W-1:0] value_res,
    output logic                      last_res,
    output logic                      empty_res,
    output logic                      overflow
);

    sus_cmd_t    cmd;
    sus_status_t status;

    sus_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (last),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    sus_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .value     (value),
        .present   (present),
        .strobe    (strobe),
        .value_res (value_res),
        .last_res  (last_res),
        .empty_res (empty_res),
        .overflow  (overflow)
    );

endmodule

[hdl/sus_ram.sv]
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module sus_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/sus_ctrl.sv]
// Controller state machine for the sort/unique set union unit.
// Depends on sus_pkg for the command and status structs.
`timescale 1ns / 1ps

module sus_ctrl
    import sus_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        last,
    input  sus_status_t status,
    output sus_cmd_t    cmd,
    output logic        busy
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PASS  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start && last)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                if (status.count_zero)
                begin
                    cmd.emit_empty = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.init_pass = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            // wait for the last read of the pass to be compared
            S_DRAIN:
            begin
                state_next = S_PASS;
            end
            S_PASS:
            begin
                cmd.pass_end = 1'b1;
                state_next   = status.found ? S_SCAN : S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

[hdl/sus_datapath.sv]
// Datapath: element store, scan registers for the minimum search, result registers.
// Depends on sus_pkg and sus_ram.
`timescale 1ns / 1ps

module sus_datapath
    import sus_pkg::*;
#(
    parameter int MAX_ITEMS = MAX_ITEMS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sus_cmd_t                  cmd,
    output sus_status_t               status,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      present,
    output logic                      strobe,
    output logic signed [VALUE_W-1:0] value_res,
    output logic                      last_res,
    output logic                      empty_res,
    output logic                      overflow
);

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);

    logic [CW-1:0]              count_reg;
    logic                       ovf_reg;
    logic [AW-1:0]              idx_reg;
    logic                       rd_valid_reg;
    logic signed [VALUE_W-1:0]  cand_reg;
    logic                       found_reg;
    logic signed [VALUE_W-1:0]  prev_reg;
    logic                       have_prev_reg;
    logic signed [VALUE_W-1:0]  pend_reg;
    logic                       pend_valid_reg;

    logic                       strobe_reg;
    logic signed [VALUE_W-1:0]  value_res_reg;
    logic                       last_res_reg;
    logic                       empty_res_reg;
    logic                       overflow_reg;

    logic                       room;
    logic                       wr_en;
    logic [VALUE_W-1:0]         rd_data;
    logic signed [VALUE_W-1:0]  rd_value;
    logic                       better;

    assign room  = (count_reg < CW'(MAX_ITEMS));
    assign wr_en = cmd.load && present && room;

    sus_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .clk   (clk),
        .we    (wr_en),
        .waddr (count_reg[AW-1:0]),
        .wdata (value),
        .re    (cmd.step),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    assign rd_value = $signed(rd_data);

    // smallest value strictly above the previously taken one
    assign better = rd_valid_reg
                    && (!have_prev_reg || (rd_value > prev_reg))
                    && (!found_reg || (rd_value < cand_reg));

    assign status.count_zero = (count_reg == '0);
    assign status.scan_last  = (CW'(idx_reg) == (count_reg - CW'(1)));
    assign status.found      = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            have_prev_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg   <= 1'b0;
            rd_valid_reg <= cmd.step;

            if (cmd.load && present)
            begin
                if (room)
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            if (cmd.step)
            begin
                idx_reg <= idx_reg + AW'(1);
            end

            if (better)
            begin
                found_reg <= 1'b1;
            end

            if (cmd.emit_empty)
            begin
                strobe_reg <= 1'b1;
                count_reg  <= '0;
                ovf_reg    <= 1'b0;
            end

            if (cmd.init_pass)
            begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                have_prev_reg  <= 1'b0;
                pend_valid_reg <= 1'b0;
            end

            if (cmd.pass_end)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
                if (found_reg)
                begin
                    // hold the new value back until we know whether it is final
                    strobe_reg     <= pend_valid_reg;
                    pend_valid_reg <= 1'b1;
                    have_prev_reg  <= 1'b1;
                end
                else
                begin
                    strobe_reg     <= 1'b1;
                    pend_valid_reg <= 1'b0;
                    have_prev_reg  <= 1'b0;
                    count_reg      <= '0;
                    ovf_reg        <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (better)
        begin
            cand_reg <= rd_value;
        end

        if (cmd.emit_empty)
        begin
            value_res_reg <= '0;
            last_res_reg  <= 1'b1;
            empty_res_reg <= 1'b1;
            overflow_reg  <= ovf_reg;
        end

        if (cmd.pass_end)
        begin
            value_res_reg <= pend_reg;
            last_res_reg  <= !found_reg;
            empty_res_reg <= 1'b0;
            overflow_reg  <= ovf_reg;
            if (found_reg)
            begin
                pend_reg <= cand_reg;
                prev_reg <= cand_reg;
            end
        end
    end

    assign strobe    = strobe_reg;
    assign value_res = value_res_reg;
    assign last_res  = last_res_reg;
    assign empty_res = empty_res_reg;
    assign overflow  = overflow_reg;

endmodule

[hdl/sus_checker.sv]
// Port-level checks for the sort/unique set union unit, bound to the top level.
// Depends on sus_pkg for the value width.
`timescale 1ns / 1ps

module sus_checker
    import sus_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      last,
    input logic                      strobe,
    input logic signed [VALUE_W-1:0] value_res,
    input logic                      last_res,
    input logic                      empty_res
);

    // an empty result is the only one of its run and carries zero
    a_empty_final : assert property (@(posedge clk) disable iff (!rst_n)
        strobe && empty_res |-> last_res && (value_res == '0))
        else $error("empty result is not a final zero result");

    // more results follow a non-final one, so the unit stays busy
    a_run_continues : assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_res |=> busy)
        else $error("unit went idle in the middle of a run");

    // a load transfer without last gives no result
    a_load_silent : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && !last |=> !strobe)
        else $error("result issued after a plain load transfer");

    // a transfer with last starts a run
    a_run_starts : assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last |=> busy)
        else $error("run did not start after the final load transfer");

endmodule

bind sort_unique_set_union_unit sus_checker u_sus_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .last      (last),
    .strobe    (strobe),
    .value_res (value_res),
    .last_res  (last_res),
    .empty_res (empty_res)
);
